[rtl/swm_pkg.sv]
// ----------------------------------------------------------------------------
// swm_pkg: shared types and constants for the sliding window median
// Cell record, control group and widths used by the cell chain and top level.
// ----------------------------------------------------------------------------
package swm_pkg;

   localparam int WINDOW_MAX = 32;
   localparam int IDX_W      = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
   localparam int COUNT_W    = $clog2(WINDOW_MAX + 1);
   localparam int WIN_W      = 6;
   localparam int SAMPLE_W   = 32;
   localparam int MEDIAN_W   = SAMPLE_W + 1;

   typedef struct packed {
      logic                       valid;
      logic signed [SAMPLE_W-1:0] value;
      logic [COUNT_W-1:0]         age;
   } cell_type;

   typedef struct packed {
      logic step;
      logic insert;
      logic clear;
   } cell_ctl_type;

endpackage

[rtl/swm_if.sv]
// ----------------------------------------------------------------------------
// swm_if: request, response and register write channels
// Valid/ready channels; a transfer happens when both are high at a clock edge.
// ----------------------------------------------------------------------------
interface swm_req_if;
   import swm_pkg::*;
   logic                       valid;
   logic                       ready;
   logic signed [SAMPLE_W-1:0] sample;
   logic                       start_req;
   modport source (output valid, sample, start_req, input ready);
   modport sink (input valid, sample, start_req, output ready);
endinterface

interface swm_rsp_if;
   import swm_pkg::*;
   logic                       valid;
   logic                       ready;
   logic signed [MEDIAN_W-1:0] median_twice;
   modport source (output valid, median_twice, input ready);
   modport sink (input valid, median_twice, output ready);
endinterface

interface swm_csr_if;
   import swm_pkg::*;
   logic             valid;
   logic             ready;
   logic [WIN_W-1:0] window_size;
   modport source (output valid, window_size, input ready);
   modport sink (input valid, window_size, output ready);
endinterface

[rtl/swm_cell.sv]
// ----------------------------------------------------------------------------
// swm_cell: one slot of the sorted window chain
// Holds one sample and its age; shifts down on removal, up on insertion.
// ----------------------------------------------------------------------------
module swm_cell (
   input  logic                               clock,
   input  logic                               reset,
   input  swm_pkg::cell_ctl_type              ctl,
   input  logic signed [swm_pkg::SAMPLE_W-1:0] sample,
   input  logic [swm_pkg::COUNT_W-1:0]        win_m1,
   input  swm_pkg::cell_type                  right_cell,
   input  logic                               rm_self,
   input  swm_pkg::cell_type                  left_shift,
   input  logic                               left_le,
   output swm_pkg::cell_type                  cell_q,
   output swm_pkg::cell_type                  shift_q,
   output logic                               le_q,
   output logic                               stale_q
);
   import swm_pkg::*;

   cell_type cell_ff;
   cell_type cell_in;
   cell_type shifted;
   cell_type fresh;
   logic     le;

   always_comb begin
      shifted = rm_self ? right_cell : cell_ff;
      if (ctl.clear) begin
         shifted.valid = 1'b0;
      end
      le = shifted.valid && ($signed(shifted.value) <= $signed(sample));
      fresh.valid = 1'b1;
      fresh.value = sample;
      fresh.age   = '0;
      cell_in = cell_ff;
      if (ctl.step) begin
         if (!ctl.insert) begin
            cell_in = shifted;
         end else if (le) begin
            cell_in     = shifted;
            cell_in.age = shifted.age + COUNT_W'(1);
         end else if (left_le) begin
            cell_in = fresh;
         end else begin
            cell_in     = left_shift;
            cell_in.age = left_shift.age + COUNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cell_ff.valid <= 1'b0;
         cell_ff.age   <= '0;
      end else begin
         cell_ff <= cell_in;
      end
   end

   assign cell_q  = cell_ff;
   assign shift_q = shifted;
   assign le_q    = le;
   assign stale_q = cell_ff.valid && (cell_ff.age >= win_m1);

endmodule

[rtl/swm_median.sv]
// ----------------------------------------------------------------------------
// swm_median: median select and response register
// Adds the two middle cells (one twice if odd); holds sum for the response.
// ----------------------------------------------------------------------------
module swm_median (
   input  logic                                                   clock,
   input  logic                                                   reset,
   input  logic                                                   load,
   input  logic                                                   taken,
   input  logic [swm_pkg::WINDOW_MAX-1:0][swm_pkg::SAMPLE_W-1:0]  values,
   input  logic [swm_pkg::COUNT_W-1:0]                            eff_win,
   output logic                                                   valid_q,
   output logic signed [swm_pkg::MEDIAN_W-1:0]                    median_q
);
   import swm_pkg::*;

   logic [IDX_W-1:0]            lo_idx;
   logic [IDX_W-1:0]            hi_idx;
   logic [SAMPLE_W-1:0]         lo_val;
   logic [SAMPLE_W-1:0]         hi_val;
   logic signed [MEDIAN_W-1:0]  sum;
   logic                        valid_ff;
   logic signed [MEDIAN_W-1:0]  median_ff;

   always_comb begin
      lo_idx = IDX_W'((eff_win - COUNT_W'(1)) >> 1);
      hi_idx = IDX_W'(eff_win >> 1);
      lo_val = values[lo_idx];
      hi_val = values[hi_idx];
      sum    = $signed({lo_val[SAMPLE_W-1], lo_val}) + $signed({hi_val[SAMPLE_W-1], hi_val});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (load) begin
         valid_ff <= 1'b1;
      end else if (taken) begin
         valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         median_ff <= sum;
      end
   end

   assign valid_q  = valid_ff;
   assign median_q = median_ff;

endmodule

[rtl/sliding_window_median.sv]
// ----------------------------------------------------------------------------
// sliding_window_median: sliding window median over signed samples
// A request that leaves the window full sets a pending flag; the median is then
// registered into the response register once it is empty or being taken.
// Throughput: one request per cycle unless a pending median cannot be loaded;
// after a shrink, requests wait while surplus old samples leave the chain.
// Reset clears all cell valid bits and the fill count at once and sets the
// window size to 1; requests are taken as soon as reset is released.
// ----------------------------------------------------------------------------
module sliding_window_median (
   input logic        clock,
   input logic        reset,
   swm_req_if.sink    req_ch,
   swm_rsp_if.source  rsp_ch,
   swm_csr_if.sink    csr_ch
);
   import swm_pkg::*;

   localparam int LAST = WINDOW_MAX - 1;

   logic [WIN_W-1:0]   win_ff;
   logic [COUNT_W-1:0] eff_win;
   logic [COUNT_W-1:0] win_m1;
   logic [COUNT_W-1:0] fill_ff;
   logic [COUNT_W-1:0] fill_in;
   logic               pend_ff;
   logic               pend_in;
   logic               free;
   logic               load;
   logic               multi;
   logic               accept;
   logic               purge;
   logic               out_valid;
   logic               sorted_ok;
   cell_ctl_type       ctl;

   cell_type           cell_q  [WINDOW_MAX];
   cell_type           shift_q [WINDOW_MAX];
   logic [WINDOW_MAX-1:0] le_q;
   logic [WINDOW_MAX-1:0] stale_q;
   logic [WINDOW_MAX-1:0] rm;
   logic [WINDOW_MAX-1:0] valid_vec;
   logic [WINDOW_MAX-1:0][SAMPLE_W-1:0] values;

   // window size register
   always_ff @(posedge clock) begin
      if (reset) begin
         win_ff <= WIN_W'(1);
      end else if (csr_ch.valid) begin
         win_ff <= csr_ch.window_size;
      end
   end

   assign csr_ch.ready = 1'b1;

   always_comb begin
      if (win_ff == '0) begin
         eff_win = COUNT_W'(1);
      end else if (int'(win_ff) > WINDOW_MAX) begin
         eff_win = COUNT_W'(WINDOW_MAX);
      end else begin
         eff_win = COUNT_W'(win_ff);
      end
      win_m1 = eff_win - COUNT_W'(1);
   end

   // removal prefix: drop the lowest stale cell
   always_comb begin
      rm[0] = stale_q[0];
      multi = 1'b0;
      for (int i = 1; i < WINDOW_MAX; i++) begin
         rm[i] = rm[i-1] | stale_q[i];
         multi = multi | (stale_q[i] & rm[i-1]);
      end
   end

   // drop surplus stale cells only while a request waits
   always_comb begin
      load   = pend_ff && (!out_valid || rsp_ch.ready);
      free   = !pend_ff || load;
      accept = req_ch.valid && !multi && free;
      purge  = req_ch.valid && multi && free;
      ctl.step   = accept || purge;
      ctl.insert = accept;
      ctl.clear  = accept && req_ch.start_req;
   end

   assign req_ch.ready = !multi && free;

   genvar g;
   generate
      for (g = 0; g < WINDOW_MAX; g++) begin : g_cell
         cell_type right_cell;
         cell_type left_shift;
         logic     left_le;
         if (g == LAST) begin : g_top
            assign right_cell = '0;
         end else begin : g_mid
            assign right_cell = cell_q[g+1];
         end
         if (g == 0) begin : g_bot
            assign left_shift = '0;
            assign left_le    = 1'b1;
         end else begin : g_up
            assign left_shift = shift_q[g-1];
            assign left_le    = le_q[g-1];
         end
         swm_cell u_cell (
            .clock      (clock),
            .reset      (reset),
            .ctl        (ctl),
            .sample     (req_ch.sample),
            .win_m1     (win_m1),
            .right_cell (right_cell),
            .rm_self    (rm[g]),
            .left_shift (left_shift),
            .left_le    (left_le),
            .cell_q     (cell_q[g]),
            .shift_q    (shift_q[g]),
            .le_q       (le_q[g]),
            .stale_q    (stale_q[g])
         );
      end
   endgenerate

   always_comb begin
      for (int i = 0; i < WINDOW_MAX; i++) begin
         values[i]    = cell_q[i].value;
         valid_vec[i] = cell_q[i].valid;
      end
   end

   // fill count and pending response
   always_comb begin
      fill_in = fill_ff;
      if (accept) begin
         if (req_ch.start_req) begin
            fill_in = COUNT_W'(1);
         end else begin
            fill_in = fill_ff - COUNT_W'(rm[LAST]) + COUNT_W'(1);
         end
      end else if (purge) begin
         fill_in = fill_ff - COUNT_W'(1);
      end
      if (accept) begin
         pend_in = (fill_in >= eff_win);
      end else if (load) begin
         pend_in = 1'b0;
      end else begin
         pend_in = pend_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= '0;
         pend_ff <= 1'b0;
      end else begin
         fill_ff <= fill_in;
         pend_ff <= pend_in;
      end
   end

   swm_median u_median (
      .clock    (clock),
      .reset    (reset),
      .load     (load),
      .taken    (rsp_ch.ready),
      .values   (values),
      .eff_win  (eff_win),
      .valid_q  (out_valid),
      .median_q (rsp_ch.median_twice)
   );

   assign rsp_ch.valid = out_valid;

   always_comb begin
      sorted_ok = 1'b1;
      for (int i = 1; i < WINDOW_MAX; i++) begin
         if (cell_q[i].valid && !(cell_q[i-1].valid &&
             ($signed(cell_q[i-1].value) <= $signed(cell_q[i].value)))) begin
            sorted_ok = 1'b0;
         end
      end
   end

   a_fill_count: assert property (@(posedge clock) disable iff (reset)
      $countones(valid_vec) == int'(fill_ff))
      else $error("fill count does not match occupied cells");

   a_sorted: assert property (@(posedge clock) disable iff (reset)
      sorted_ok)
      else $error("cell chain lost sorted prefix order");

   a_start: assert property (@(posedge clock) disable iff (reset)
      accept && req_ch.start_req |=> fill_ff == COUNT_W'(1))
      else $error("start request did not restart the window");

   a_pend_full: assert property (@(posedge clock) disable iff (reset)
      pend_ff |-> fill_ff >= eff_win)
      else $error("response pending with window not full");

endmodule

[tb/sv/tb_sliding_window_median.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_sliding_window_median: self-checking bench for the sliding window median
// Streams signed samples through the request channel under several window
// sizes and compares each doubled median against a sorted-window predictor.
// ----------------------------------------------------------------------------
module tb_sliding_window_median;
   import swm_pkg::*;

   localparam int LIMIT      = 2000;
   localparam int LONG_HOLD  = 100;
   localparam int SETTLE     = 40;
   localparam int MAX_REPORT = 10;

   localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 32'sh7fff_ffff;
   localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = 32'sh8000_0000;

   typedef struct {
      logic signed [SAMPLE_W-1:0] sample;
      logic                       start;
   } window_request_type;

   logic clock = 1'b1;
   logic reset = 1'b1;

   swm_req_if req_ch();
   swm_rsp_if rsp_ch();
   swm_csr_if csr_ch();

   sliding_window_median dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   always #4 clock = ~clock;

   window_request_type          sample_queue[$];
   logic signed [MEDIAN_W-1:0]  median_queue[$];

   logic signed [SAMPLE_W-1:0]  cell_val [WINDOW_MAX];
   logic [WIN_W-1:0]            cell_age [WINDOW_MAX];
   int                          cell_count;
   logic [WIN_W-1:0]            window_cfg;

   int  requests_queued = 0;
   int  requests_taken  = 0;
   int  csr_writes      = 0;
   int  mismatches      = 0;
   int  gap_pct         = 0;
   int  hold_asked      = 0;
   int  hold_seen       = 0;
   int  req_gap         = 0;
   int  rsp_stall       = 0;
   int  quiet_cycles    = 0;
   logic req_fire;
   window_request_type next_req;
   logic signed [MEDIAN_W-1:0] want_median;
   logic signed [MEDIAN_W-1:0] got_median;
   bit   has_median;

   function automatic void advance_window(input logic signed [SAMPLE_W-1:0] s,
                                          input logic start,
                                          output bit produced,
                                          output logic signed [MEDIAN_W-1:0] median);
      int w, n, pos, i;
      if (window_cfg == 0) w = 1;
      else if (window_cfg > WINDOW_MAX) w = WINDOW_MAX;
      else w = int'(window_cfg);
      if (start) cell_count = 0;
      n = 0;
      for (i = 0; i < cell_count; i++) begin
         if (int'(cell_age[i]) + 1 < w) begin
            cell_val[n] = cell_val[i];
            cell_age[n] = cell_age[i] + 1'b1;
            n++;
         end
      end
      pos = n;
      while (pos > 0 && cell_val[pos-1] > s) begin
         cell_val[pos] = cell_val[pos-1];
         cell_age[pos] = cell_age[pos-1];
         pos--;
      end
      cell_val[pos] = s;
      cell_age[pos] = '0;
      cell_count = n + 1;
      produced = (cell_count >= w);
      median = '0;
      if (produced) begin
         if (w % 2 == 1) median = {cell_val[(w-1)/2], 1'b0};
         else median = MEDIAN_W'(longint'(cell_val[w/2-1]) + longint'(cell_val[w/2]));
      end
   endfunction

   // request driver
   always @(negedge clock) begin
      if (reset) begin
         req_ch.valid     <= 1'b0;
         req_ch.sample    <= '0;
         req_ch.start_req <= 1'b0;
         req_gap          <= 0;
      end else if (!req_ch.valid || req_fire) begin
         if (req_gap > 0) begin
            req_ch.valid <= 1'b0;
            req_gap      <= req_gap - 1;
         end else if (sample_queue.size() != 0 && gap_pct != 0
                      && $urandom_range(99) < gap_pct) begin
            req_ch.valid <= 1'b0;
            req_gap      <= $urandom_range(3);
         end else if (sample_queue.size() != 0) begin
            next_req = sample_queue.pop_front();
            req_ch.valid     <= 1'b1;
            req_ch.sample    <= next_req.sample;
            req_ch.start_req <= next_req.start;
         end else begin
            req_ch.valid <= 1'b0;
         end
      end
   end

   // response ready, with short stalls and one long hold-off on demand
   always @(negedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b1;
         rsp_stall    <= 0;
      end else if (hold_seen != hold_asked) begin
         hold_seen    <= hold_asked;
         rsp_stall    <= LONG_HOLD;
         rsp_ch.ready <= 1'b0;
      end else if (rsp_stall > 0) begin
         rsp_stall    <= rsp_stall - 1;
         rsp_ch.ready <= 1'b0;
      end else if (gap_pct != 0 && $urandom_range(99) < gap_pct) begin
         rsp_stall    <= $urandom_range(3);
         rsp_ch.ready <= 1'b0;
      end else begin
         rsp_ch.ready <= 1'b1;
      end
   end

   // monitor: predict on each request, check each response
   always @(posedge clock) begin
      if (reset) begin
         req_fire   <= 1'b0;
         window_cfg = 6'd1;
         cell_count = 0;
      end else begin
         req_fire <= req_ch.valid && req_ch.ready;
         if (csr_ch.valid && csr_ch.ready) begin
            window_cfg = csr_ch.window_size;
            csr_writes++;
         end
         if (rsp_ch.valid && rsp_ch.ready) begin
            got_median = rsp_ch.median_twice;
            if (median_queue.size() == 0) begin
               mismatches++;
               if (mismatches <= MAX_REPORT)
                  $display("%0t: unexpected median_twice %0d", $realtime, got_median);
            end else begin
               want_median = median_queue.pop_front();
               if (got_median !== want_median) begin
                  mismatches++;
                  if (mismatches <= MAX_REPORT)
                     $display("%0t: median_twice expected %0d actual %0d",
                              $realtime, want_median, got_median);
               end
            end
         end
         if (req_ch.valid && req_ch.ready) begin
            advance_window(req_ch.sample, req_ch.start_req, has_median, want_median);
            if (has_median) median_queue = {median_queue, want_median};
            requests_taken++;
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)
          || (csr_ch.valid && csr_ch.ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   task automatic push_request(input logic signed [SAMPLE_W-1:0] s, input logic start);
      window_request_type r;
      r.sample = s;
      r.start  = start;
      sample_queue = {sample_queue, r};
      requests_queued++;
   endtask

   task automatic write_window(input logic [WIN_W-1:0] size);
      int target;
      target = csr_writes + 1;
      csr_ch.valid       <= 1'b1;
      csr_ch.window_size <= size;
      while (csr_writes != target) @(negedge clock);
      csr_ch.valid <= 1'b0;
   endtask

   task automatic wait_drained();
      while (sample_queue.size() != 0 || requests_taken != requests_queued
             || median_queue.size() != 0)
         @(negedge clock);
      repeat (SETTLE) @(negedge clock);
   endtask

   task automatic queue_random_samples(input int count, input int start_pct);
      logic signed [SAMPLE_W-1:0] s;
      int i;
      for (i = 0; i < count; i++) begin
         case ($urandom_range(3))
            0, 1: s = $urandom;
            2:    s = $signed($urandom_range(16)) - 8;
            default: begin
               case ($urandom_range(3))
                  0:       s = SAMPLE_MAX - $urandom_range(1);
                  1:       s = SAMPLE_MIN + $urandom_range(1);
                  2:       s = '0;
                  default: s = -1;
               endcase
            end
         endcase
         push_request(s, $urandom_range(99) < start_pct);
      end
   endtask

   initial begin
      int phase, eff;
      logic [WIN_W-1:0] size;
      csr_ch.valid       = 1'b0;
      csr_ch.window_size = '0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // window of one after reset
      push_request(SAMPLE_MAX, 1'b1);
      push_request(SAMPLE_MIN, 1'b0);
      push_request(32'sd0, 1'b0);
      push_request(-32'sd1, 1'b0);
      wait_drained();

      // grow to an even window mid-sequence
      write_window(6'd2);
      push_request(SAMPLE_MAX, 1'b0);
      push_request(SAMPLE_MAX, 1'b0);
      push_request(SAMPLE_MIN, 1'b0);
      push_request(SAMPLE_MIN, 1'b0);
      wait_drained();

      // grow again, with equal samples
      write_window(6'd5);
      push_request(32'sd3, 1'b0);
      push_request(-32'sd7, 1'b0);
      push_request(32'sd3, 1'b0);
      push_request(32'sd3, 1'b0);
      push_request(32'sd100, 1'b0);
      wait_drained();

      // shrink mid-sequence
      write_window(6'd3);
      push_request(SAMPLE_MIN, 1'b0);
      push_request(32'sd1, 1'b0);
      push_request(SAMPLE_MAX, 1'b0);
      wait_drained();

      // zero acts as one, oversize acts as the maximum
      write_window(6'd0);
      push_request(-32'sd5, 1'b1);
      push_request(32'sd9, 1'b0);
      wait_drained();

      write_window(6'd63);
      push_request(32'sd11, 1'b1);
      push_request(-32'sd11, 1'b0);
      push_request(32'sd0, 1'b0);
      wait_drained();

      for (phase = 0; phase < 13; phase++) begin
         case ($urandom_range(5))
            0:       size = WIN_W'($urandom_range(3));
            1:       size = WIN_W'($urandom_range(8, 1));
            2:       size = 6'd32;
            3:       size = WIN_W'($urandom_range(63, 33));
            default: size = WIN_W'($urandom_range(32, 1));
         endcase
         if (phase == 4) size = 6'd32;
         eff = (size == 0) ? 1 : (size > WINDOW_MAX) ? WINDOW_MAX : int'(size);
         gap_pct = (phase >= 11) ? 0 : (phase % 3) * 25;
         write_window(size);
         queue_random_samples(60, 30 / eff + 1);
         if (phase == 4) hold_asked++;
         wait_drained();
      end

      if (mismatches == 0 && median_queue.size() == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule
